// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int unsigned START_W = 16;
  localparam int unsigned SIZE_W  = 17;

  // chunk table entry
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOFIT    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  // table select
  typedef enum logic {
    TAB_FREE = 1'b0,
    TAB_USED = 1'b1
  } tab_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_DISPATCH,
    ST_REM_CHK,
    ST_REM_WR,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over a byte-offset heap with start-sorted free and
// allocated chunk tables held in two RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request beat: in_kind
//   selects allocate or free, in_req_size is the allocate size, in_address
//   the start offset to free. Each request yields exactly one result beat on
//   out_valid/out_stall: out_address_res (granted offset, else 0) and
//   out_status (ok, no fit / zero size, table full, not found).
//   One request is in flight at a time. The time taken grows with the free
//   or used table entries scanned and the entries shifted by the remove and
//   insert passes, since each table RAM has a single read port and is
//   walked one entry at a time; a zero-size allocate skips the scan.
//   After reset the block writes the initial free chunk (offset 0,
//   HEAP_SIZE bytes) into the free table, with in_stall high.
//   The result sits in an output register; a new request is taken while a
//   stalled result waits, and the next result holds in its final state
//   until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core #(
  parameter int unsigned HEAP_SIZE   = 65536,
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [16:0] in_req_size,
  input  wire logic [15:0] in_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_address_res,
  output logic [1:0]       out_status
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(ffha_pkg::entry_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // control registers
  ffha_pkg::state_t  state_r, state_nxt;
  ffha_pkg::kind_t   kind_r, kind_nxt;
  ffha_pkg::tab_t    tsel_r, tsel_nxt;
  ffha_pkg::status_t res_status_r, res_status_nxt;
  logic [CW-1:0]     fcnt_r, fcnt_nxt;
  logic [CW-1:0]     ucnt_r, ucnt_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload registers
  logic [16:0] req_r, req_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] start_r, start_nxt;
  logic [16:0] size_r, size_nxt;
  logic [15:0] res_addr_r, res_addr_nxt;
  logic [15:0] out_address_res_r, out_address_res_nxt;
  ffha_pkg::status_t out_status_r, out_status_nxt;

  // RAM ports
  logic          f_we, u_we;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] f_rdata, u_rdata;
  ffha_pkg::entry_t rd_ent, ins_ent, init_ent;
  logic          wr_en;

  ffha_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_free_tab (
    .clk   (clk),
    .we    (f_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (f_rdata)
  );

  ffha_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_used_tab (
    .clk   (clk),
    .we    (u_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (u_rdata)
  );

  assign rd_ent = (tsel_r == ffha_pkg::TAB_USED) ? ffha_pkg::entry_t'(u_rdata)
                                                 : ffha_pkg::entry_t'(f_rdata);
  assign f_we   = wr_en && (tsel_r == ffha_pkg::TAB_FREE);
  assign u_we   = wr_en && (tsel_r == ffha_pkg::TAB_USED);

  assign init_ent = '{start: '0, size: 17'(HEAP_SIZE)};

  // entry to insert, by request kind and step
  always_comb begin
    ins_ent.start = start_r;
    ins_ent.size  = size_r;
    if (kind_r == ffha_pkg::KIND_ALLOC) begin
      if (phase_r == 2'd1) begin
        ins_ent.size = req_r;                          // new allocation
      end else begin
        ins_ent.start = 16'(17'(start_r) + req_r);     // leftover tail
        ins_ent.size  = size_r - req_r;
      end
    end
  end

  always_comb begin
    logic [CW-1:0] cnt;
    cnt = (tsel_r == ffha_pkg::TAB_USED) ? ucnt_r : fcnt_r;

    state_nxt           = state_r;
    kind_nxt            = kind_r;
    tsel_nxt            = tsel_r;
    res_status_nxt      = res_status_r;
    fcnt_nxt            = fcnt_r;
    ucnt_nxt            = ucnt_r;
    j_nxt               = j_r;
    idx_nxt             = idx_r;
    phase_nxt           = phase_r;
    req_nxt             = req_r;
    addr_nxt            = addr_r;
    start_nxt           = start_r;
    size_nxt            = size_r;
    res_addr_nxt        = res_addr_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_address_res_nxt = out_address_res_r;
    out_status_nxt      = out_status_r;
    in_stall            = 1'b1;
    wr_en               = 1'b0;
    wr_addr             = j_r[IW-1:0];
    wr_data             = EW'(ins_ent);
    rd_addr             = j_r[IW-1:0];

    unique case (state_r)
      ffha_pkg::ST_INIT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = EW'(init_ent);
        state_nxt = ffha_pkg::ST_IDLE;
      end

      ffha_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          kind_nxt     = ffha_pkg::kind_t'(in_kind);
          req_nxt      = in_req_size;
          addr_nxt     = in_address;
          tsel_nxt     = in_kind ? ffha_pkg::TAB_USED : ffha_pkg::TAB_FREE;
          j_nxt        = '0;
          phase_nxt    = '0;
          res_addr_nxt = '0;
          if (!in_kind && in_req_size == '0) begin
            res_status_nxt = ffha_pkg::STATUS_NOFIT;
            state_nxt      = ffha_pkg::ST_DONE;
          end else begin
            state_nxt = ffha_pkg::ST_SCAN_RD;
          end
        end
      end

      // linear scan: read, then check, one entry at a time
      ffha_pkg::ST_SCAN_RD: begin
        if (j_r < cnt) begin
          state_nxt = ffha_pkg::ST_SCAN_CK;
        end else begin
          res_status_nxt = (kind_r == ffha_pkg::KIND_FREE) ? ffha_pkg::STATUS_NOTFOUND
                                                          : ffha_pkg::STATUS_NOFIT;
          state_nxt = ffha_pkg::ST_DONE;
        end
      end

      ffha_pkg::ST_SCAN_CK: begin
        if ((kind_r == ffha_pkg::KIND_ALLOC && rd_ent.size >= req_r) ||
            (kind_r == ffha_pkg::KIND_FREE && rd_ent.start == addr_r)) begin
          idx_nxt   = j_r;
          start_nxt = rd_ent.start;
          size_nxt  = rd_ent.size;
          if ((kind_r == ffha_pkg::KIND_ALLOC && ucnt_r >= DEPTH_C) ||
              (kind_r == ffha_pkg::KIND_FREE && fcnt_r >= DEPTH_C)) begin
            res_status_nxt = ffha_pkg::STATUS_FULL;
            state_nxt      = ffha_pkg::ST_DONE;
          end else begin
            state_nxt = ffha_pkg::ST_DISPATCH;
          end
        end else begin
          j_nxt     = j_r + ONE_C;
          state_nxt = ffha_pkg::ST_SCAN_RD;
        end
      end

      // alloc: remove free[idx], insert used, insert tail
      // free : insert free, remove used[idx]
      ffha_pkg::ST_DISPATCH: begin
        res_status_nxt = ffha_pkg::STATUS_OK;
        if (kind_r == ffha_pkg::KIND_ALLOC) begin
          res_addr_nxt = start_r;
          unique case (phase_r)
            2'd0: begin
              tsel_nxt  = ffha_pkg::TAB_FREE;
              j_nxt     = idx_r;
              state_nxt = ffha_pkg::ST_REM_CHK;
            end
            2'd1: begin
              tsel_nxt  = ffha_pkg::TAB_USED;
              j_nxt     = ucnt_r;
              state_nxt = ffha_pkg::ST_INS_CHK;
            end
            2'd2: begin
              if (size_r != req_r) begin
                tsel_nxt  = ffha_pkg::TAB_FREE;
                j_nxt     = fcnt_r;
                state_nxt = ffha_pkg::ST_INS_CHK;
              end else begin
                state_nxt = ffha_pkg::ST_DONE;
              end
            end
            default: state_nxt = ffha_pkg::ST_DONE;
          endcase
        end else begin
          unique case (phase_r)
            2'd0: begin
              tsel_nxt  = ffha_pkg::TAB_FREE;
              j_nxt     = fcnt_r;
              state_nxt = ffha_pkg::ST_INS_CHK;
            end
            2'd1: begin
              tsel_nxt  = ffha_pkg::TAB_USED;
              j_nxt     = idx_r;
              state_nxt = ffha_pkg::ST_REM_CHK;
            end
            default: state_nxt = ffha_pkg::ST_DONE;
          endcase
        end
      end

      // remove: pull entries j+1.. down by one
      ffha_pkg::ST_REM_CHK: begin
        rd_addr = IW'(j_r + ONE_C);
        if (j_r + ONE_C < cnt) begin
          state_nxt = ffha_pkg::ST_REM_WR;
        end else begin
          if (tsel_r == ffha_pkg::TAB_USED) ucnt_nxt = ucnt_r - ONE_C;
          else fcnt_nxt = fcnt_r - ONE_C;
          phase_nxt = phase_r + 2'd1;
          state_nxt = ffha_pkg::ST_DISPATCH;
        end
      end

      ffha_pkg::ST_REM_WR: begin
        wr_en     = 1'b1;
        wr_data   = EW'(rd_ent);
        j_nxt     = j_r + ONE_C;
        state_nxt = ffha_pkg::ST_REM_CHK;
      end

      // insert: push larger starts up by one, from the top down
      ffha_pkg::ST_INS_CHK: begin
        rd_addr = IW'(j_r - ONE_C);
        if (j_r != '0) begin
          state_nxt = ffha_pkg::ST_INS_CMP;
        end else begin
          wr_en = 1'b1;
          if (tsel_r == ffha_pkg::TAB_USED) ucnt_nxt = ucnt_r + ONE_C;
          else fcnt_nxt = fcnt_r + ONE_C;
          phase_nxt = phase_r + 2'd1;
          state_nxt = ffha_pkg::ST_DISPATCH;
        end
      end

      ffha_pkg::ST_INS_CMP: begin
        wr_en = 1'b1;
        if (ins_ent.start < rd_ent.start) begin
          wr_data   = EW'(rd_ent);
          j_nxt     = j_r - ONE_C;
          state_nxt = ffha_pkg::ST_INS_CHK;
        end else begin
          if (tsel_r == ffha_pkg::TAB_USED) ucnt_nxt = ucnt_r + ONE_C;
          else fcnt_nxt = fcnt_r + ONE_C;
          phase_nxt = phase_r + 2'd1;
          state_nxt = ffha_pkg::ST_DISPATCH;
        end
      end

      ffha_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_address_res_nxt = (res_status_r == ffha_pkg::STATUS_OK) ? res_addr_r : '0;
          out_status_nxt      = res_status_r;
          state_nxt           = ffha_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ffha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffha_pkg::ST_INIT;
      fcnt_r       <= ONE_C;
      ucnt_r       <= '0;
      out_valid_r  <= 1'b0;
      kind_r       <= ffha_pkg::KIND_ALLOC;
      tsel_r       <= ffha_pkg::TAB_FREE;
      res_status_r <= ffha_pkg::STATUS_OK;
      j_r          <= '0;
      idx_r        <= '0;
      phase_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      fcnt_r       <= fcnt_nxt;
      ucnt_r       <= ucnt_nxt;
      out_valid_r  <= out_valid_nxt;
      kind_r       <= kind_nxt;
      tsel_r       <= tsel_nxt;
      res_status_r <= res_status_nxt;
      j_r          <= j_nxt;
      idx_r        <= idx_nxt;
      phase_r      <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r             <= req_nxt;
    addr_r            <= addr_nxt;
    start_r           <= start_nxt;
    size_r            <= size_nxt;
    res_addr_r        <= res_addr_nxt;
    out_address_res_r <= out_address_res_nxt;
    out_status_r      <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_address_res = out_address_res_r;
  assign out_status      = out_status_r;

  // table counts stay within the RAM depth
  a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= DEPTH_C) else $error("free count overflow");

  a_ucnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ucnt_r <= DEPTH_C) else $error("used count overflow");

  // a fresh result only comes out of the final state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ffha_pkg::ST_DONE))
    else $error("result without done");

  // requests only enter while idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> state_r == ffha_pkg::ST_IDLE)
    else $error("accept outside idle");

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
